### rtl/assert_macros.svh
// Assertion macros for the lane marking row filter RTL.
// Included by lmrf_run_gen for its concurrent checks; no other dependency.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Property must hold at every clock edge outside reset.
`define LMRF_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error("assertion failed: lbl");

// Expression must never be true outside reset.
`define LMRF_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
	else $error("forbidden condition: lbl");

`else

`define LMRF_ASSERT(lbl, clk, rst_n, prop)
`define LMRF_NEVER(lbl, clk, rst_n, expr)

`endif

`endif

### rtl/lmrf_pkg.sv
// Package of the lane marking row filter: widths, limits, register indexes,
// reset values, the run request type and the filter helper functions. No dependencies.
`default_nettype none

package lmrf_pkg;

	localparam int MAX_MARK_WIDTH = 32;
	localparam int MAX_IMAGE_SIDE = 4096;

	localparam int PIX_W   = 8;
	localparam int SIDE_W  = 13;
	localparam int MARK_W  = 5;
	localparam int THR_W   = 8;

	// Working width of the clamped mark distance.
	localparam int MW_W    = $clog2(MAX_MARK_WIDTH);
	// Depth of the pixel chain and the index width into it.
	localparam int DEPTH   = 2 * MAX_MARK_WIDTH - 1;
	localparam int TAP_W   = $clog2(DEPTH);
	// Results per request go up to MAX_MARK_WIDTH.
	localparam int CNT_W   = $clog2(MAX_MARK_WIDTH + 1);

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 13;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IMAGE_WIDTH    = 2'd0,
		REG_IMAGE_HEIGHT   = 2'd1,
		REG_MARKING_WIDTH  = 2'd2,
		REG_EDGE_THRESHOLD = 2'd3
	} lmrf_reg_t;

	localparam logic [SIDE_W-1:0] RST_IMAGE_WIDTH    = SIDE_W'(640);
	localparam logic [SIDE_W-1:0] RST_IMAGE_HEIGHT   = SIDE_W'(480);
	localparam logic [MARK_W-1:0] RST_MARKING_WIDTH  = MARK_W'(20);
	localparam logic [THR_W-1:0]  RST_EDGE_THRESHOLD = THR_W'(40);

	localparam logic [PIX_W-1:0] MARK_ON  = '1;
	localparam logic [PIX_W-1:0] MARK_OFF = '0;

	// One run of results caused by an accepted pixel: the value of its first
	// result (every later one is zero), how many results, and whether the run
	// closes a row.
	typedef struct packed {
		logic [PIX_W-1:0] value;
		logic [CNT_W-1:0] count;
		logic             row_end;
	} lmrf_run_t;

	// Zero acts as one, anything above the largest side acts as the largest side.
	function automatic logic [SIDE_W-1:0] side_clamp(input logic [SIDE_W-1:0] v);
		logic [SIDE_W-1:0] r;
		if (v == '0) begin
			r = SIDE_W'(1);
		end else if (v > SIDE_W'(MAX_IMAGE_SIDE)) begin
			r = SIDE_W'(MAX_IMAGE_SIDE);
		end else begin
			r = v;
		end
		return r;
	endfunction

	// Mark distance limited to 1 .. MAX_MARK_WIDTH-1.
	function automatic logic [MW_W-1:0] mark_clamp(input logic [MARK_W-1:0] v);
		logic [MARK_W-1:0] r;
		if (v == '0) begin
			r = MARK_W'(1);
		end else if (v > MARK_W'(MAX_MARK_WIDTH - 1)) begin
			r = MARK_W'(MAX_MARK_WIDTH - 1);
		end else begin
			r = v;
		end
		return MW_W'(r);
	endfunction

	// 2c - l - r - |l - r| equals 2 * (c - max(l, r)); clamp and threshold it.
	function automatic logic [PIX_W-1:0] mark_decide(
		input logic [PIX_W-1:0] c,
		input logic [PIX_W-1:0] l,
		input logic [PIX_W-1:0] r,
		input logic [THR_W-1:0] thr
	);
		logic [PIX_W-1:0] mx;
		logic [PIX_W-1:0] diff;
		logic [PIX_W:0]   dbl;
		logic [PIX_W-1:0] clamped;
		logic [PIX_W-1:0] res;
		mx = (l > r) ? l : r;
		diff = c - mx;
		dbl = {diff, 1'b0};
		clamped = dbl[PIX_W] ? '1 : dbl[PIX_W-1:0];
		if (c == '0 || c <= mx) begin
			res = MARK_OFF;
		end else if (clamped > thr) begin
			res = MARK_ON;
		end else begin
			res = MARK_OFF;
		end
		return res;
	endfunction

endpackage

`default_nettype wire

### rtl/lmrf_cell.sv
// One cell of the pixel chain: holds one pixel and takes its neighbor's on a shift.
// Depends on lmrf_pkg.
`default_nettype none

module lmrf_cell (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     shift,
	input  wire logic [lmrf_pkg::PIX_W-1:0] d,
	output logic      [lmrf_pkg::PIX_W-1:0] q
);
	import lmrf_pkg::*;

	logic [PIX_W-1:0] pix_q;

	// The chain starts out all zero after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_q <= '0;
		end else if (shift) begin
			pix_q <= d;
		end
	end

	assign q = pix_q;

endmodule

`default_nettype wire

### rtl/lmrf_delay_line.sv
// Pixel delay line of the lane marking row filter: a chain of lmrf_cell with
// taps at distance W and 2W behind the incoming pixel. Depends on lmrf_pkg, lmrf_cell.
`default_nettype none

module lmrf_delay_line (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      shift,
	input  wire logic [lmrf_pkg::PIX_W-1:0] pixel_in,
	input  wire logic [lmrf_pkg::MW_W-1:0]  mark_w,
	output logic      [lmrf_pkg::PIX_W-1:0] tap_c,
	output logic      [lmrf_pkg::PIX_W-1:0] tap_l
);
	import lmrf_pkg::*;

	logic [PIX_W-1:0] line [DEPTH];
	logic [TAP_W-1:0] c_idx;
	logic [TAP_W-1:0] l_idx;

	// Cell 0 takes the new pixel, every other cell takes its neighbor's.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		if (i == 0) begin : g_head
			lmrf_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.shift  (shift),
				.d      (pixel_in),
				.q      (line[i])
			);
		end else begin : g_body
			lmrf_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.shift  (shift),
				.d      (line[i-1]),
				.q      (line[i])
			);
		end
	end

	// Before the shift, the centre pixel sits at W-1 and the left one at 2W-1.
	assign c_idx = TAP_W'(mark_w) - TAP_W'(1);
	assign l_idx = (TAP_W'(mark_w) << 1) - TAP_W'(1);
	assign tap_c = line[c_idx];
	assign tap_l = line[l_idx];

endmodule

`default_nettype wire

### rtl/lmrf_run_gen.sv
// Result sequencer of the lane marking row filter: holds one run request and
// plays it out through a registered output stage. Depends on lmrf_pkg, assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module lmrf_run_gen (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       load,
	input  wire lmrf_pkg::lmrf_run_t        run_in,
	output logic                            load_ready,
	output logic                            m_tvalid,
	input  wire logic                       m_tready,
	output logic      [lmrf_pkg::PIX_W-1:0] m_edge_value,
	output logic                            m_row_end,
	output logic                            m_last_of_run
);
	import lmrf_pkg::*;

	logic [CNT_W-1:0] cnt_q;
	logic [PIX_W-1:0] val_q;
	logic             row_end_q;
	logic             out_valid_q;
	logic [PIX_W-1:0] out_value_q;
	logic             out_row_end_q;
	logic             out_last_q;
	logic             out_free;
	logic             emit;
	logic             final_item;

	assign out_free   = !out_valid_q || m_tready;
	assign emit       = out_free && (cnt_q != '0);
	assign final_item = (cnt_q == CNT_W'(1));

	// A new request is taken once the held run is empty or hands over its last item now.
	assign load_ready = (cnt_q == '0) || (final_item && out_free);

	// Run register: only the first result carries a computed value.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			val_q     <= '0;
			row_end_q <= 1'b0;
		end else if (load) begin
			cnt_q     <= run_in.count;
			val_q     <= run_in.value;
			row_end_q <= run_in.row_end;
		end else if (emit) begin
			cnt_q <= cnt_q - CNT_W'(1);
			val_q <= MARK_OFF;
		end
	end

	// Output stage: refilled whenever it is empty or being taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= (cnt_q != '0);
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_value_q   <= val_q;
			out_row_end_q <= row_end_q && final_item;
			out_last_q    <= final_item;
		end
	end

	assign m_tvalid      = out_valid_q;
	assign m_edge_value  = out_value_q;
	assign m_row_end     = out_row_end_q;
	assign m_last_of_run = out_last_q;

	// A row end is always the final result of its run.
	`LMRF_ASSERT(a_row_end_is_last, clk, arst_n, out_valid_q |-> (!out_row_end_q || out_last_q))
	// Results are binary marks.
	`LMRF_ASSERT(a_binary_mark, clk, arst_n, out_valid_q |-> (out_value_q == MARK_ON || out_value_q == MARK_OFF))
	// A stalled output freezes a pending run.
	`LMRF_ASSERT(a_stall_holds_run, clk, arst_n, (out_valid_q && !m_tready && cnt_q != '0) |=> $stable(cnt_q))
	// Results after the first of a run are zero.
	`LMRF_ASSERT(a_tail_zero, clk, arst_n, (emit && !load) |=> (val_q == MARK_OFF))
	// A run never grows beyond the longest flush.
	`LMRF_NEVER(a_count_bound, clk, arst_n, cnt_q > CNT_W'(MAX_MARK_WIDTH))

endmodule

`default_nettype wire

### rtl/lane_marking_row_filter_core.sv
// Top level of the lane marking row filter: configuration registers, row and
// column counters, the filter decision and the run request. Depends on lmrf_pkg,
// lmrf_delay_line, lmrf_run_gen.
//
//  Channel  | Handshake          | Payload
//  ---------+--------------------+------------------------------------------------
//  s_*      | s_tvalid/s_tready  | s_tdata = pixel, s_tuser = frame_start
//  m_*      | m_tvalid/m_tready  | m_tdata = edge_value, m_tuser = row_end,
//           |                    | m_tlast = last_of_run
//  cfg_*    | cfg_valid/cfg_ready| cfg_index = register, cfg_data = value
//
// One pixel is taken per cycle unless a run or stall holds it back; its result leaves
// through a one-entry output register. The last pixel of a row starts a run of up to
// W+1 results, one per cycle unless stalled, and the next pixel is taken in the cycle
// the final result of that run enters the output. When m_tready is low, s_tready drops
// as soon as the run register cannot hand over. Reset clears the pixel chain, the
// counters and all handshake state; there is no clearing pass before pixels are taken.
`default_nettype none

module lane_marking_row_filter_core (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// Pixel input.
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	input  wire logic [7:0]                      s_tdata,  // [7:0] pixel
	input  wire logic                            s_tuser,  // [0] frame_start
	// Result output.
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	output logic      [7:0]                      m_tdata,  // [7:0] edge_value
	output logic                                 m_tlast,  // last_of_run
	output logic                                 m_tuser,  // [0] row_end
	// Register writes.
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [lmrf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [lmrf_pkg::CFG_DATA_W-1:0] cfg_data
);
	import lmrf_pkg::*;

	logic [SIDE_W-1:0] image_width_q;
	logic [SIDE_W-1:0] image_height_q;
	logic [MARK_W-1:0] marking_width_q;
	logic [THR_W-1:0]  edge_threshold_q;
	logic [SIDE_W-1:0] col_q;
	logic [SIDE_W-1:0] row_q;

	logic              accept;
	logic [SIDE_W-1:0] wid;
	logic [SIDE_W-1:0] hgt;
	logic [MW_W-1:0]   mark_w;
	logic [SIDE_W-1:0] col;
	logic [SIDE_W-1:0] row;
	logic              row_last;
	logic              col_ge_w;
	logic              forced_zero;
	logic [PIX_W-1:0]  tap_c;
	logic [PIX_W-1:0]  tap_l;
	logic [PIX_W-1:0]  decided;
	lmrf_run_t         run_req;
	logic              load_ready;

	// Register writes are always taken.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q    <= RST_IMAGE_WIDTH;
			image_height_q   <= RST_IMAGE_HEIGHT;
			marking_width_q  <= RST_MARKING_WIDTH;
			edge_threshold_q <= RST_EDGE_THRESHOLD;
		end else if (cfg_valid) begin
			unique case (lmrf_reg_t'(cfg_index))
				REG_IMAGE_WIDTH:    image_width_q    <= cfg_data[SIDE_W-1:0];
				REG_IMAGE_HEIGHT:   image_height_q   <= cfg_data[SIDE_W-1:0];
				REG_MARKING_WIDTH:  marking_width_q  <= cfg_data[MARK_W-1:0];
				REG_EDGE_THRESHOLD: edge_threshold_q <= cfg_data[THR_W-1:0];
				default: ;
			endcase
		end
	end

	// Effective geometry after clamping.
	assign wid    = side_clamp(image_width_q);
	assign hgt    = side_clamp(image_height_q);
	assign mark_w = mark_clamp(marking_width_q);

	assign s_tready = load_ready;
	assign accept   = s_tvalid && load_ready;

	// Position of the incoming pixel; a frame start puts it at the origin.
	assign col      = s_tuser ? '0 : col_q;
	assign row      = s_tuser ? '0 : row_q;
	assign row_last = ({1'b0, col} + (SIDE_W+1)'(1)) >= {1'b0, wid};
	assign col_ge_w = col >= SIDE_W'(mark_w);

	lmrf_delay_line u_delay_line (
		.clk      (clk),
		.arst_n   (arst_n),
		.shift    (accept),
		.pixel_in (s_tdata),
		.mark_w   (mark_w),
		.tap_c    (tap_c),
		.tap_l    (tap_l)
	);

	// The output column is col-W; it is blank in the upper half and near either border.
	assign forced_zero = (row < (hgt >> 1))
		|| (col < (SIDE_W'(mark_w) << 1))
		|| (col >= wid);
	assign decided = mark_decide(tap_c, tap_l, s_tdata, edge_threshold_q);

	// Run request: a row end flushes the trailing columns, other pixels give one result
	// once W pixels of the row are in.
	always_comb begin
		run_req.value   = (col_ge_w && !forced_zero) ? decided : MARK_OFF;
		run_req.row_end = row_last;
		if (row_last) begin
			run_req.count = col_ge_w ? (CNT_W'(mark_w) + CNT_W'(1))
				: (col[CNT_W-1:0] + CNT_W'(1));
		end else begin
			run_req.count = col_ge_w ? CNT_W'(1) : '0;
		end
	end

	// Column and row counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (row_last) begin
				col_q <= '0;
				row_q <= (({1'b0, row} + (SIDE_W+1)'(1)) >= {1'b0, hgt}) ? '0
					: row + SIDE_W'(1);
			end else begin
				col_q <= col + SIDE_W'(1);
				row_q <= row;
			end
		end
	end

	lmrf_run_gen u_run_gen (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (accept),
		.run_in        (run_req),
		.load_ready    (load_ready),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_edge_value  (m_tdata),
		.m_row_end     (m_tuser),
		.m_last_of_run (m_tlast)
	);

endmodule

`default_nettype wire
